/* hw/rtl/bfp_pkg.sv */
// Package for the biosignal frame parser: frame layout constants and the
// control struct passed from the frame controller to the top level.
// No dependencies.
package bfp_pkg;

  // Configuration of the frame layout.
  localparam int NUM_CHANNELS  = 8;
  localparam int NUM_AUX_BYTES = 6;
  localparam int MAX_CHANNELS  = 8;
  localparam int MAX_AUX_BYTES = 6;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int CHAN_W = 24;
  localparam int AUX_W  = BYTE_W * MAX_AUX_BYTES;
  localparam int POS_W  = 6;

  // Frame positions, counted from the start byte as position 1.
  localparam int CHAN_FIRST = 3;
  localparam int AUX_FIRST  = CHAN_FIRST + 3 * NUM_CHANNELS;
  localparam int END_POS    = AUX_FIRST + NUM_AUX_BYTES;

  // Bytes two up to the one before the closing byte sit in the cell chain.
  localparam int CHAIN_LEN = END_POS - 2;

  localparam logic [POS_W-1:0]  END_POS_V  = POS_W'(END_POS);
  localparam logic [POS_W-1:0]  FIRST_POS  = POS_W'(1);
  localparam logic [BYTE_W-1:0] START_BYTE = 8'hA0;
  localparam logic [BYTE_W-1:0] LOW_MASK   = 8'h80;

  // Frame hunting state.
  typedef enum logic {
    ST_HUNT,
    ST_FRAME
  } frame_state_t;

  // Control from the frame controller.
  typedef struct packed {
    logic emit;          // closing byte accepted: capture the chain
    logic last_pending;  // next accepted byte may close the frame
  } frame_ctrl_t;

endpackage

/* hw/rtl/biosignal_frame_parser.sv */
// Biosignal frame parser: takes one received byte per transaction and deframes
// 33-byte packets opened by 0xA0; a start byte restarts the frame anywhere.
// Depends on bfp_pkg, bfp_cell and bfp_ctrl.
//
// The parser accepts one byte every clock cycle while input ready is high.
// Each accepted byte moves through a chain of 31 byte cells, so when the
// closing byte arrives the chain already holds the sample number, the eight
// channel words and the six auxiliary bytes; they are captured into the
// output register in that same cycle and the result is offered in the cycle
// after the closing byte is accepted. Input ready stays high except when a
// result is still waiting to be taken and the next byte could close another
// frame. There is no start-up delay after reset.
module biosignal_frame_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bfp_pkg::BYTE_W-1:0]        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bfp_pkg::BYTE_W-1:0]        out_sample_number,
  output logic signed [bfp_pkg::CHAN_W-1:0] out_channel_1,
  output logic signed [bfp_pkg::CHAN_W-1:0] out_channel_2,
  output logic signed [bfp_pkg::CHAN_W-1:0] out_channel_3,
  output logic signed [bfp_pkg::CHAN_W-1:0] out_channel_4,
  output logic signed [bfp_pkg::CHAN_W-1:0] out_channel_5,
  output logic signed [bfp_pkg::CHAN_W-1:0] out_channel_6,
  output logic signed [bfp_pkg::CHAN_W-1:0] out_channel_7,
  output logic signed [bfp_pkg::CHAN_W-1:0] out_channel_8,
  output logic [bfp_pkg::AUX_W-1:0]         out_aux_bytes
);
  import bfp_pkg::*;

  logic                     accept;
  frame_ctrl_t              ctrl;
  logic [BYTE_W-1:0]        tap [CHAIN_LEN+1];
  logic signed [CHAN_W-1:0] chan_nxt [MAX_CHANNELS];
  logic signed [CHAN_W-1:0] chan_r [MAX_CHANNELS];
  logic [AUX_W-1:0]         aux_nxt;
  logic [AUX_W-1:0]         aux_r;
  logic [BYTE_W-1:0]        sample_r;
  logic                     out_valid_r, out_valid_nxt;

  // Hold off only when a waiting result could be overwritten.
  assign in_ready = !(ctrl.last_pending && out_valid_r && !out_ready);
  assign accept   = in_valid && in_ready;

  bfp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .ctrl    (ctrl)
  );

  // Chain of byte cells; tap[n] holds the byte accepted n transactions ago.
  assign tap[0] = in_rx_byte;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
    bfp_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .d_in     (tap[i]),
      .d_out    (tap[i+1])
    );
  end

  // Channel words from the chain; frame byte p sits at tap[END_POS - p].
  for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_chan
    if (k < NUM_CHANNELS) begin : g_used
      localparam int HI = END_POS - (CHAN_FIRST + 3 * k);
      assign chan_nxt[k] = {tap[HI], tap[HI-1], tap[HI-2] & LOW_MASK};
    end else begin : g_unused
      assign chan_nxt[k] = '0;
    end
  end

  // Auxiliary bytes, first received in the top byte.
  for (genvar j = 0; j < MAX_AUX_BYTES; j++) begin : g_aux
    if (j < NUM_AUX_BYTES) begin : g_used
      assign aux_nxt[AUX_W-1-BYTE_W*j -: BYTE_W] = tap[END_POS - AUX_FIRST - j];
    end else begin : g_unused
      assign aux_nxt[AUX_W-1-BYTE_W*j -: BYTE_W] = '0;
    end
  end

  // Output register valid flag.
  assign out_valid_nxt = ctrl.emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload, captured when the closing byte is accepted.
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      sample_r <= tap[CHAIN_LEN];
      chan_r   <= chan_nxt;
      aux_r    <= aux_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_number = sample_r;
  assign out_channel_1     = chan_r[0];
  assign out_channel_2     = chan_r[1];
  assign out_channel_3     = chan_r[2];
  assign out_channel_4     = chan_r[3];
  assign out_channel_5     = chan_r[4];
  assign out_channel_6     = chan_r[5];
  assign out_channel_7     = chan_r[6];
  assign out_channel_8     = chan_r[7];
  assign out_aux_bytes     = aux_r;

endmodule

/* hw/rtl/bfp_cell.sv */
// One byte cell of the frame chain: holds a byte and hands it on to the next
// cell on every accepted transaction.
// Depends on bfp_pkg.
module bfp_cell (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [bfp_pkg::BYTE_W-1:0] d_in,
  output logic [bfp_pkg::BYTE_W-1:0] d_out
);
  import bfp_pkg::*;

  logic [BYTE_W-1:0] data_r;

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d_in;
    end
  end

  assign d_out = data_r;

endmodule

/* hw/rtl/bfp_ctrl.sv */
// Frame controller: tracks whether a frame is open and the position of the
// last byte taken, and flags the closing byte.
// Depends on bfp_pkg.
module bfp_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [bfp_pkg::BYTE_W-1:0] rx_byte,
  output bfp_pkg::frame_ctrl_t       ctrl
);
  import bfp_pkg::*;

  frame_state_t     state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pos_inc;
  logic             is_start;

  assign pos_inc  = pos_r + FIRST_POS;
  assign is_start = (rx_byte == START_BYTE);

  // Next state and position.
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    if (accept) begin
      if (is_start) begin
        state_nxt = ST_FRAME;
        pos_nxt   = FIRST_POS;
      end else begin
        case (state_r)
          ST_FRAME: begin
            pos_nxt = pos_inc;
            if (pos_inc >= END_POS_V) begin
              state_nxt = ST_HUNT;
            end
          end
          default: begin
            state_nxt = ST_HUNT;
          end
        endcase
      end
    end
  end

  // Control outputs.
  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_FRAME: begin
        ctrl.last_pending = (pos_inc == END_POS_V);
        ctrl.emit         = accept && !is_start && (pos_inc == END_POS_V);
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

/* hw/rtl/bfp_checker.sv */
// Port-level checker for the biosignal frame parser, bound to the top level.
// Depends on bfp_pkg and biosignal_frame_parser.
module bfp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [bfp_pkg::BYTE_W-1:0]        in_rx_byte,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [bfp_pkg::BYTE_W-1:0]        out_sample_number,
  input logic signed [bfp_pkg::CHAN_W-1:0] out_channel_1,
  input logic signed [bfp_pkg::CHAN_W-1:0] out_channel_8,
  input logic [bfp_pkg::AUX_W-1:0]         out_aux_bytes
);
  import bfp_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_number)
      && $stable(out_channel_1) && $stable(out_aux_bytes))
    else $error("result payload changed while stalled");

  // A start byte never closes a frame.
  a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_rx_byte == START_BYTE) |=> !$rose(out_valid))
    else $error("result raised after a start byte");

  // A new result follows an accepted byte.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result raised without an accepted byte");

  // Channel words always have their low seven bits cleared.
  a_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_channel_1[6:0] == 7'd0) && (out_channel_8[6:0] == 7'd0))
    else $error("channel low bits not cleared");

endmodule

bind biosignal_frame_parser bfp_checker u_bfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_rx_byte        (in_rx_byte),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_sample_number (out_sample_number),
  .out_channel_1     (out_channel_1),
  .out_channel_8     (out_channel_8),
  .out_aux_bytes     (out_aux_bytes)
);
